FILE: rtl/core/gor_pkg.sv
// Shared types and constants of the partition table overlay block router.
`timescale 1ns / 1ps

package gor_pkg;

  localparam int unsigned BLK_W = 13;
  localparam int unsigned JOBQ_DEPTH = 2;

  localparam logic [4:0]  MIN_SHIFT = 5'd9;
  localparam logic [4:0]  MAX_SHIFT = 5'd16;
  localparam logic [5:0]  MAX_TABLE_BLOCKS = 6'd32;
  localparam logic [5:0]  HEADER_BLOCKS = 6'd2;
  localparam logic [31:0] DEFAULT_VOLUME_ID = 32'h5359_4E54;

  typedef enum logic [2:0] {
    CFG_PASS_THROUGH  = 3'd0,
    CFG_WRITE_LOCKED  = 3'd1,
    CFG_BLOCK_SHIFT   = 3'd2,
    CFG_TABLE_BLOCKS  = 3'd3,
    CFG_BACKING_BASE  = 3'd4,
    CFG_EXTENT_BLOCKS = 3'd5,
    CFG_VOLUME_ID     = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_MEDIA     = 2'd2,
    ST_WRITE_PROT = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    RG_FORWARD     = 3'd0,
    RG_BOOT        = 3'd1,
    RG_PRIM_HEADER = 3'd2,
    RG_BACK_HEADER = 3'd3,
    RG_PRIM_ENTRY  = 3'd4,
    RG_BACK_ENTRY  = 3'd5,
    RG_DROPPED     = 3'd6
  } region_e;

  typedef struct packed {
    logic        operation;
    logic [31:0] request_media;
    logic [47:0] first_block;
    logic [31:0] byte_count;
    logic        buffer_present;
  } req_t;

  typedef struct packed {
    status_e     status;
    region_e     region;
    logic [47:0] target_block;
    logic [4:0]  table_offset;
    logic [6:0]  run_length;
    logic        last;
  } res_t;

  typedef struct packed {
    logic        pass_through;
    logic        write_locked;
    logic [4:0]  block_shift;
    logic [5:0]  table_blocks;
    logic [47:0] backing_base;
    logic [47:0] extent_blocks;
    logic [31:0] volume_id;
  } cfg_raw_t;

  localparam cfg_raw_t CFG_RESET = '{
    pass_through:  1'b0,
    write_locked:  1'b0,
    block_shift:   5'd9,
    table_blocks:  6'd32,
    backing_base:  48'd0,
    extent_blocks: 48'd1,
    volume_id:     DEFAULT_VOLUME_ID
  };

  // Layout of the virtual disk, worked out once whenever a register changes.
  typedef struct packed {
    logic        pass_through;
    logic        write_locked;
    logic [4:0]  shift;
    logic [5:0]  eb;
    logic [5:0]  dstart;
    logic [31:0] volume_id;
    logic [47:0] base_adj;
    logic [48:0] dend;
    logic [48:0] last_lba;
    logic [48:0] total;
  } geom_t;

  typedef struct packed {
    status_e           status;
    logic              fast;
    logic              is_write;
    logic [47:0]       lba;
    logic [BLK_W-1:0]  blocks;
  } job_t;

endpackage

FILE: rtl/core/gpt_overlay_block_router.sv
// Top level of the partition table overlay block router.
`timescale 1ns / 1ps

// A request word is taken when start_i is high and busy_o is low; busy_o rises
// only when the validator holds a word and the two-entry job queue is full.
// An accepted word is registered and validated from that register, and goes
// into the queue once the queue is not full. The back end then gives a
// rejected request or a request that is forwarded as one run a single result
// in the cycle after it leaves the queue; a request that touches the table
// gives one result per block on consecutive cycles. The back end's one result
// per cycle sets the sustained rate. Results appear on res_o for exactly one
// cycle with res_valid_o high and cannot be held off, so the receiver must take
// every word as it comes. Configuration writes take effect on the next cycle.
module gpt_overlay_block_router #(
  parameter int unsigned MAX_RUN_BLOCKS = 64,
  parameter int unsigned ADDRESS_BITS   = 48
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_idx_i,
  input  logic [47:0]    cfg_wdata_i,
  input  logic           start_i,
  input  gor_pkg::req_t  req_i,
  output logic           busy_o,
  output logic           res_valid_o,
  output gor_pkg::res_t  res_o
);

  gor_pkg::geom_t geom;
  gor_pkg::job_t  front_job;
  gor_pkg::job_t  back_job;
  logic           push;
  logic           pop;
  logic           full;
  logic           empty;

  gor_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .geom_o      (geom)
  );

  gor_front #(
    .MAX_RUN_BLOCKS (MAX_RUN_BLOCKS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .req_i   (req_i),
    .geom_i  (geom),
    .full_i  (full),
    .push_o  (push),
    .job_o   (front_job),
    .busy_o  (busy_o)
  );

  gor_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (back_job)
  );

  gor_back #(
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .job_i       (back_job),
    .pop_o       (pop),
    .geom_i      (geom),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

FILE: rtl/core/gor_cfg.sv
// Configuration registers and the derived virtual disk layout.
`timescale 1ns / 1ps

module gor_cfg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [47:0]           cfg_wdata_i,
  output gor_pkg::geom_t        geom_o
);

  function automatic gor_pkg::geom_t derive(input gor_pkg::cfg_raw_t r);
    logic [4:0] sh;
    logic [5:0] tb;
    logic [5:0] eb;
    logic [5:0] ds;
    logic [6:0] ds_eb;
    gor_pkg::geom_t g;
    if (r.block_shift < gor_pkg::MIN_SHIFT) begin
      sh = gor_pkg::MIN_SHIFT;
    end else if (r.block_shift > gor_pkg::MAX_SHIFT) begin
      sh = gor_pkg::MAX_SHIFT;
    end else begin
      sh = r.block_shift;
    end
    tb = (r.table_blocks > gor_pkg::MAX_TABLE_BLOCKS) ? gor_pkg::MAX_TABLE_BLOCKS
                                                      : r.table_blocks;
    eb = r.pass_through ? 6'd0 : tb;
    ds = r.pass_through ? 6'd0 : gor_pkg::HEADER_BLOCKS + eb;
    ds_eb = {1'b0, ds} + {1'b0, eb};
    g.pass_through = r.pass_through;
    g.write_locked = r.write_locked;
    g.shift        = sh;
    g.eb           = eb;
    g.dstart       = ds;
    g.volume_id    = r.volume_id;
    g.base_adj     = r.backing_base - {42'd0, ds};
    g.dend         = {1'b0, r.extent_blocks} + {43'd0, ds};
    g.last_lba     = {1'b0, r.extent_blocks} + {42'd0, ds_eb};
    g.total        = r.pass_through ? {1'b0, r.extent_blocks}
                                    : {1'b0, r.extent_blocks} + {42'd0, ds_eb + 7'd1};
    return g;
  endfunction

  gor_pkg::cfg_raw_t cfg_d, cfg_q;
  gor_pkg::geom_t    geom_d, geom_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (gor_pkg::cfg_idx_e'(cfg_idx_i))
        gor_pkg::CFG_PASS_THROUGH:  cfg_d.pass_through  = cfg_wdata_i[0];
        gor_pkg::CFG_WRITE_LOCKED:  cfg_d.write_locked  = cfg_wdata_i[0];
        gor_pkg::CFG_BLOCK_SHIFT:   cfg_d.block_shift   = cfg_wdata_i[4:0];
        gor_pkg::CFG_TABLE_BLOCKS:  cfg_d.table_blocks  = cfg_wdata_i[5:0];
        gor_pkg::CFG_BACKING_BASE:  cfg_d.backing_base  = cfg_wdata_i;
        gor_pkg::CFG_EXTENT_BLOCKS: cfg_d.extent_blocks = cfg_wdata_i;
        gor_pkg::CFG_VOLUME_ID:     cfg_d.volume_id     = cfg_wdata_i[31:0];
        default: ;
      endcase
    end
    geom_d = derive(cfg_d);
  end

  // The layout is registered in the same edge as the write, so it is ready at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q  <= gor_pkg::CFG_RESET;
      geom_q <= derive(gor_pkg::CFG_RESET);
    end else begin
      cfg_q  <= cfg_d;
      geom_q <= geom_d;
    end
  end

  assign geom_o = geom_q;

endmodule

FILE: rtl/core/gor_front.sv
// Front end: takes a request word, validates it and classifies it into a job.
`timescale 1ns / 1ps

module gor_front #(
  parameter int unsigned MAX_RUN_BLOCKS = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  gor_pkg::req_t   req_i,
  input  gor_pkg::geom_t  geom_i,
  input  logic            full_i,
  output logic            push_o,
  output gor_pkg::job_t   job_o,
  output logic            busy_o
);

  gor_pkg::req_t req_q;
  logic          vld_d, vld_q;
  logic          accept;

  logic [15:0]   low_mask;
  logic [31:0]   blocks_w;
  logic [48:0]   lba_w;
  logic [48:0]   end_sum;
  logic          bad_buf;
  logic          too_long;
  logic          past_end;
  logic          in_data;

  assign busy_o = vld_q && full_i;
  assign accept = start_i && !busy_o;
  assign push_o = vld_q && !full_i;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (push_o) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
  end

  // Block size is a power of two, so the remainder is just the low bits.
  assign low_mask = 16'((17'd1 << geom_i.shift) - 17'd1);
  assign blocks_w = req_q.byte_count >> geom_i.shift;
  assign lba_w    = {1'b0, req_q.first_block};
  assign end_sum  = lba_w + {17'd0, blocks_w};

  assign bad_buf  = !req_q.buffer_present || (req_q.byte_count == 32'd0) ||
                    ((req_q.byte_count[15:0] & low_mask) != 16'd0);
  assign too_long = blocks_w > 32'(MAX_RUN_BLOCKS);
  assign past_end = end_sum > geom_i.total;
  assign in_data  = (lba_w >= {43'd0, geom_i.dstart}) && (end_sum <= geom_i.dend);

  always_comb begin
    job_o.fast     = geom_i.pass_through || in_data;
    job_o.is_write = req_q.operation;
    job_o.lba      = req_q.first_block;
    job_o.blocks   = blocks_w[gor_pkg::BLK_W-1:0];
    priority if (req_q.operation && geom_i.write_locked) begin
      job_o.status = gor_pkg::ST_WRITE_PROT;
    end else if (bad_buf || too_long || past_end) begin
      job_o.status = gor_pkg::ST_INVALID;
    end else if (req_q.request_media != geom_i.volume_id) begin
      job_o.status = gor_pkg::ST_MEDIA;
    end else begin
      job_o.status = gor_pkg::ST_OK;
    end
  end

endmodule

FILE: rtl/core/gor_fifo.sv
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps

module gor_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  gor_pkg::job_t  job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output gor_pkg::job_t  job_o
);

  localparam int unsigned PtrW = (gor_pkg::JOBQ_DEPTH > 1) ? $clog2(gor_pkg::JOBQ_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(gor_pkg::JOBQ_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(gor_pkg::JOBQ_DEPTH - 1);

  gor_pkg::job_t   mem_q [gor_pkg::JOBQ_DEPTH];
  logic [PtrW-1:0] wr_ptr_d, wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_d, rd_ptr_q;
  logic [CntW-1:0] cnt_d, cnt_q;
  logic            do_push;
  logic            do_pop;

  assign full_o  = cnt_q == CntW'(gor_pkg::JOBQ_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

FILE: rtl/core/gor_back.sv
// Back end: turns a job into result words, one block per cycle on the split path.
`timescale 1ns / 1ps

module gor_back #(
  parameter int unsigned ADDRESS_BITS = 48
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  gor_pkg::job_t   job_i,
  output logic            pop_o,
  input  gor_pkg::geom_t  geom_i,
  output logic            res_valid_o,
  output gor_pkg::res_t   res_o
);

  localparam logic [47:0] AddrMask = (ADDRESS_BITS >= 48) ? 48'hFFFF_FFFF_FFFF
                                   : 48'((64'd1 << ADDRESS_BITS) - 64'd1);

  typedef enum logic [1:0] {
    BK_IDLE  = 2'b01,
    BK_SPLIT = 2'b10
  } back_state_e;

  back_state_e              state_d, state_q;
  logic [48:0]              cur_d, cur_q;
  logic [gor_pkg::BLK_W-1:0] left_d, left_q;
  logic                     wr_d, wr_q;
  logic                     res_valid_d, res_valid_q;
  gor_pkg::res_t            res_d, res_q;
  gor_pkg::res_t            split_res;

  assign pop_o = (state_q == BK_IDLE) && !empty_i;

  // Classification of the block under the cursor; earlier tests take priority.
  // The cursor is one bit wider than an address, as a run may pass the top of it.
  always_comb begin
    split_res.status       = gor_pkg::ST_OK;
    split_res.run_length   = 7'd1;
    split_res.last         = left_q == gor_pkg::BLK_W'(1);
    split_res.target_block = cur_q[47:0];
    split_res.table_offset = 5'd0;
    priority if (cur_q == 49'd0) begin
      split_res.region = gor_pkg::RG_BOOT;
    end else if (cur_q == 49'd1) begin
      split_res.region = gor_pkg::RG_PRIM_HEADER;
    end else if (cur_q == geom_i.last_lba) begin
      split_res.region = gor_pkg::RG_BACK_HEADER;
    end else if (cur_q >= 49'(gor_pkg::HEADER_BLOCKS) && cur_q < {43'd0, geom_i.dstart}) begin
      split_res.region       = gor_pkg::RG_PRIM_ENTRY;
      split_res.table_offset = cur_q[4:0] - gor_pkg::HEADER_BLOCKS[4:0];
    end else if (cur_q >= geom_i.dend && cur_q < geom_i.last_lba) begin
      split_res.region       = gor_pkg::RG_BACK_ENTRY;
      split_res.table_offset = cur_q[4:0] - geom_i.dend[4:0];
    end else begin
      split_res.region       = gor_pkg::RG_FORWARD;
      split_res.target_block = (geom_i.base_adj + cur_q[47:0]) & AddrMask;
    end
    // Table blocks are never written through.
    if (wr_q && split_res.region != gor_pkg::RG_FORWARD) begin
      split_res.region       = gor_pkg::RG_DROPPED;
      split_res.table_offset = 5'd0;
    end
  end

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    left_d      = left_q;
    wr_d        = wr_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    unique case (state_q)
      BK_IDLE: begin
        if (pop_o) begin
          if (job_i.status != gor_pkg::ST_OK) begin
            res_valid_d        = 1'b1;
            res_d.status       = job_i.status;
            res_d.region       = gor_pkg::RG_FORWARD;
            res_d.target_block = 48'd0;
            res_d.table_offset = 5'd0;
            res_d.run_length   = 7'd0;
            res_d.last         = 1'b1;
          end else if (job_i.fast) begin
            res_valid_d        = 1'b1;
            res_d.status       = gor_pkg::ST_OK;
            res_d.region       = gor_pkg::RG_FORWARD;
            res_d.target_block = (geom_i.base_adj + job_i.lba) & AddrMask;
            res_d.table_offset = 5'd0;
            res_d.run_length   = 7'(job_i.blocks);
            res_d.last         = 1'b1;
          end else begin
            cur_d   = {1'b0, job_i.lba};
            left_d  = job_i.blocks;
            wr_d    = job_i.is_write;
            state_d = BK_SPLIT;
          end
        end
      end
      BK_SPLIT: begin
        res_valid_d = 1'b1;
        res_d       = split_res;
        cur_d       = cur_q + 49'd1;
        left_d      = left_q - 1'b1;
        if (split_res.last) begin
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      res_valid_q <= 1'b0;
      left_q      <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      left_q      <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    wr_q  <= wr_d;
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

FILE: rtl/core/gor_chk.sv
// Port checker for the block router, bound to the top level.
`timescale 1ns / 1ps

module gor_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          res_valid_o,
  input gor_pkg::res_t res_o
);

  // A request split per block delivers its words on consecutive cycles.
  a_split_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |=> res_valid_o)
    else $error("split request broke off before its final word");

  // A rejection is always a lone, empty word.
  a_error_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status != gor_pkg::ST_OK |->
      res_o.last && res_o.run_length == 7'd0 && res_o.region == gor_pkg::RG_FORWARD &&
      res_o.target_block == 48'd0)
    else $error("error word carries a payload");

  // Table words cover exactly one block.
  a_table_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.region != gor_pkg::RG_FORWARD |->
      res_o.run_length == 7'd1 && res_o.status == gor_pkg::ST_OK)
    else $error("table word does not cover one block");

  // A run of more than one block only comes as the single word of a request.
  a_run_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.run_length > 7'd1 |-> res_o.last)
    else $error("multi-block run is not the final word");

endmodule

bind gpt_overlay_block_router gor_chk u_gor_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

FILE: bench/tb_gpt_overlay_block_router.sv
// Self-checking testbench for the partition table overlay block router.
`timescale 1ns / 1ps

module tb_gpt_overlay_block_router;

  localparam int unsigned RUN_LIMIT       = 64;
  localparam int unsigned ADDR_BITS       = 48;
  localparam int unsigned N_PHASES        = 12;
  localparam int unsigned ITEMS_PER_PHASE = 13;
  localparam int unsigned SETTLE          = 8;
  localparam logic        OP_READ         = 1'b0;
  localparam logic        OP_WRITE        = 1'b1;
  localparam logic [2:0]  CFG_NONE        = 3'd7;
  localparam logic [31:0] VOL_RST         = gor_pkg::DEFAULT_VOLUME_ID;
  localparam logic [63:0] ADDR_MASK =
    (ADDR_BITS >= 64) ? '1 : ((64'd1 << ADDR_BITS) - 64'd1);

  typedef struct {
    bit            is_cfg;
    logic [2:0]    idx;
    logic [47:0]   wdata;
    gor_pkg::req_t req;
    bit            typed;
    gor_pkg::res_t want;
  } step_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we_i = 1'b0;
  logic [2:0]    cfg_idx_i = '0;
  logic [47:0]   cfg_wdata_i = '0;
  logic          start_i = 1'b0;
  gor_pkg::req_t req_i = '0;
  logic          busy_o;
  logic          res_valid_o;
  gor_pkg::res_t res_o;

  gor_pkg::cfg_raw_t shadow = gor_pkg::CFG_RESET;
  gor_pkg::res_t     due[$];
  int                mismatches = 0;
  bit                gaps_on = 1'b1;

  gpt_overlay_block_router #(
    .MAX_RUN_BLOCKS(RUN_LIMIT),
    .ADDRESS_BITS  (ADDR_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .start_i    (start_i),
    .req_i      (req_i),
    .busy_o     (busy_o),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [47:0] rnd48();
    return {16'($urandom), $urandom};
  endfunction

  // Keeps the low bits of a register value and fills the unused upper bits with noise.
  function automatic logic [47:0] dress(logic [47:0] v, int unsigned w);
    logic [47:0] mask;
    mask = (48'd1 << w) - 48'd1;
    return (rnd48() & ~mask) | (v & mask);
  endfunction

  function automatic gor_pkg::req_t ask(logic op, logic [31:0] media, logic [47:0] lba,
                                        logic [31:0] bytes, logic has_buf);
    gor_pkg::req_t r;
    r.operation      = op;
    r.request_media  = media;
    r.first_block    = lba;
    r.byte_count     = bytes;
    r.buffer_present = has_buf;
    return r;
  endfunction

  function automatic gor_pkg::res_t refusal(gor_pkg::status_e s);
    gor_pkg::res_t w;
    w = '0;
    w.status = s;
    w.last   = 1'b1;
    return w;
  endfunction

  function automatic gor_pkg::res_t routed(gor_pkg::region_e rg, logic [63:0] tgt,
                                           logic [63:0] off, logic [63:0] run, logic fin);
    gor_pkg::res_t w;
    w.status       = gor_pkg::ST_OK;
    w.region       = rg;
    w.target_block = 48'(tgt & ADDR_MASK);
    w.table_offset = off[4:0];
    w.run_length   = run[6:0];
    w.last         = fin;
    return w;
  endfunction

  function automatic step_t do_cfg(logic [2:0] idx, logic [47:0] v);
    step_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.idx    = idx;
    s.wdata  = v;
    return s;
  endfunction

  function automatic step_t do_req(gor_pkg::req_t r);
    step_t s;
    s = '{default: '0};
    s.req = r;
    return s;
  endfunction

  function automatic step_t do_req_exp(gor_pkg::req_t r, gor_pkg::res_t w);
    step_t s;
    s = do_req(r);
    s.typed = 1'b1;
    s.want  = w;
    return s;
  endfunction

  // Effective geometry of the virtual disk under the current register values.
  function automatic void layout(output logic [63:0] sh, output logic [63:0] eb,
                                 output logic [63:0] ds, output logic [63:0] tot);
    if (shadow.block_shift < gor_pkg::MIN_SHIFT) sh = 64'(gor_pkg::MIN_SHIFT);
    else if (shadow.block_shift > gor_pkg::MAX_SHIFT) sh = 64'(gor_pkg::MAX_SHIFT);
    else sh = 64'(shadow.block_shift);
    if (shadow.pass_through) eb = 64'd0;
    else if (shadow.table_blocks > gor_pkg::MAX_TABLE_BLOCKS) eb = 64'(gor_pkg::MAX_TABLE_BLOCKS);
    else eb = 64'(shadow.table_blocks);
    ds  = shadow.pass_through ? 64'd0 : 64'(gor_pkg::HEADER_BLOCKS) + eb;
    tot = shadow.pass_through ? 64'(shadow.extent_blocks)
                              : ds + 64'(shadow.extent_blocks) + eb + 64'd1;
  endfunction

  function automatic void route_request(gor_pkg::req_t r);
    logic [63:0]      sh, eb, ds, tot, nb, lba, last_lba, bk, cur, off, i;
    gor_pkg::region_e rg;
    logic             fin;
    layout(sh, eb, ds, tot);
    lba = 64'(r.first_block);
    if (r.operation && shadow.write_locked) begin
      due.push_back(refusal(gor_pkg::ST_WRITE_PROT));
      return;
    end
    if (!r.buffer_present || r.byte_count == '0 ||
        (64'(r.byte_count) & ((64'd1 << sh) - 64'd1)) != 64'd0) begin
      due.push_back(refusal(gor_pkg::ST_INVALID));
      return;
    end
    nb = 64'(r.byte_count) >> sh;
    if (nb > 64'(RUN_LIMIT) || lba + nb > tot) begin
      due.push_back(refusal(gor_pkg::ST_INVALID));
      return;
    end
    if (r.request_media != shadow.volume_id) begin
      due.push_back(refusal(gor_pkg::ST_MEDIA));
      return;
    end
    if (shadow.pass_through ||
        (lba >= ds && lba + nb <= ds + 64'(shadow.extent_blocks))) begin
      due.push_back(routed(gor_pkg::RG_FORWARD, 64'(shadow.backing_base) + (lba - ds),
                           64'd0, nb, 1'b1));
      return;
    end
    // Split path: one word per block, each named after the table region it falls in.
    last_lba = tot - 64'd1;
    bk       = last_lba - eb;
    for (i = 0; i < nb; i++) begin
      cur = lba + i;
      off = 64'd0;
      fin = (i + 64'd1 == nb);
      if (cur == 64'd0) rg = gor_pkg::RG_BOOT;
      else if (cur == 64'd1) rg = gor_pkg::RG_PRIM_HEADER;
      else if (cur == last_lba) rg = gor_pkg::RG_BACK_HEADER;
      else if (cur >= 64'(gor_pkg::HEADER_BLOCKS) &&
               cur < 64'(gor_pkg::HEADER_BLOCKS) + eb) begin
        rg  = gor_pkg::RG_PRIM_ENTRY;
        off = cur - 64'(gor_pkg::HEADER_BLOCKS);
      end else if (cur >= bk && cur < last_lba) begin
        rg  = gor_pkg::RG_BACK_ENTRY;
        off = cur - bk;
      end else begin
        rg = gor_pkg::RG_FORWARD;
      end
      if (rg == gor_pkg::RG_FORWARD)
        due.push_back(routed(gor_pkg::RG_FORWARD, 64'(shadow.backing_base) + (cur - ds),
                             64'd0, 64'd1, fin));
      else if (r.operation)
        due.push_back(routed(gor_pkg::RG_DROPPED, cur, 64'd0, 64'd1, fin));
      else
        due.push_back(routed(rg, cur, off, 64'd1, fin));
    end
  endfunction

  // Mostly well-formed requests aimed at the region boundaries; the rest is noise.
  function automatic gor_pkg::req_t draw_request();
    logic [63:0]   sh, eb, ds, tot, nb, anchor, back;
    gor_pkg::req_t r;
    r = ask(1'($urandom_range(1)), $urandom, rnd48(), $urandom, 1'($urandom_range(1)));
    if ($urandom_range(3) == 0) return r;
    layout(sh, eb, ds, tot);
    if ($urandom_range(15) == 0) nb = 64'($urandom_range(65, 80));
    else if ($urandom_range(1) == 0) nb = 64'($urandom_range(1, 4));
    else nb = 64'($urandom_range(1, RUN_LIMIT));
    case ($urandom_range(4))
      0: anchor = 64'd0;
      1: anchor = ds;
      2: anchor = ds + 64'(shadow.extent_blocks);
      3: anchor = tot;
      default: anchor = 64'(rnd48()) % (tot + 64'd1);
    endcase
    back   = 64'($urandom_range(32'(nb) + 2));
    anchor = (anchor > back) ? anchor - back : 64'd0;
    anchor = anchor + 64'($urandom_range(2));
    r.first_block    = anchor[47:0];
    r.byte_count     = 32'(nb << sh);
    r.buffer_present = 1'b1;
    if ($urandom_range(15) != 0) r.request_media = shadow.volume_id;
    return r;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [47:0] v);
    case (idx)
      gor_pkg::CFG_PASS_THROUGH:  shadow.pass_through  = v[0];
      gor_pkg::CFG_WRITE_LOCKED:  shadow.write_locked  = v[0];
      gor_pkg::CFG_BLOCK_SHIFT:   shadow.block_shift   = v[4:0];
      gor_pkg::CFG_TABLE_BLOCKS:  shadow.table_blocks  = v[5:0];
      gor_pkg::CFG_BACKING_BASE:  shadow.backing_base  = v;
      gor_pkg::CFG_EXTENT_BLOCKS: shadow.extent_blocks = v;
      gor_pkg::CFG_VOLUME_ID:     shadow.volume_id     = v[31:0];
      default: ;
    endcase
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [47:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    apply_reg(idx, v);
    cfg_we_i <= 1'b0;
    // Give the layout time to settle before the next word.
    repeat (4) @(posedge clk_i);
  endtask

  // Waits at a posedge until the request word is taken, then records its results.
  task automatic issue(gor_pkg::req_t r, bit typed, gor_pkg::res_t want);
    if (gaps_on && $urandom_range(2) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= r;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (typed) due.push_back(want);
    else route_request(r);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    gor_pkg::res_t want;
    if (rst_ni && res_valid_o) begin
      if (due.size() == 0) begin
        $error("result word with nothing outstanding: %h", res_o);
        mismatches++;
      end else begin
        want = due.pop_front();
        check_field("status", want.status, res_o.status);
        check_field("region", want.region, res_o.region);
        check_field("target_block", want.target_block, res_o.target_block);
        check_field("table_offset", want.table_offset, res_o.table_offset);
        check_field("run_length", want.run_length, res_o.run_length);
        check_field("last", want.last, res_o.last);
      end
    end
  end

  initial begin : stimulus
    step_t       plan[$];
    logic        pass, lock;
    logic [4:0]  shift;
    logic [5:0]  tbl;
    logic [47:0] base, ext;
    logic [31:0] vol;
    int unsigned ph, n, k;

    // Reset layout: data block 34, primary entries 2..33, backup 35..66, header 67.
    plan.push_back(do_req_exp(ask(OP_READ, VOL_RST, 48'd34, 32'd512, 1'b1),
                              routed(gor_pkg::RG_FORWARD, 64'd0, 64'd0, 64'd1, 1'b1)));
    plan.push_back(do_req_exp(ask(OP_READ, VOL_RST, 48'd0, 32'd512, 1'b1),
                              routed(gor_pkg::RG_BOOT, 64'd0, 64'd0, 64'd1, 1'b1)));
    plan.push_back(do_req_exp(ask(OP_READ, VOL_RST, 48'd1, 32'd512, 1'b1),
                              routed(gor_pkg::RG_PRIM_HEADER, 64'd1, 64'd0, 64'd1, 1'b1)));
    plan.push_back(do_req_exp(ask(OP_READ, VOL_RST, 48'd67, 32'd512, 1'b1),
                              routed(gor_pkg::RG_BACK_HEADER, 64'd67, 64'd0, 64'd1, 1'b1)));
    plan.push_back(do_req_exp(ask(OP_READ, VOL_RST, 48'd66, 32'd512, 1'b1),
                              routed(gor_pkg::RG_BACK_ENTRY, 64'd66, 64'd31, 64'd1, 1'b1)));
    plan.push_back(do_req_exp(ask(OP_WRITE, VOL_RST, 48'd66, 32'd512, 1'b1),
                              routed(gor_pkg::RG_DROPPED, 64'd66, 64'd0, 64'd1, 1'b1)));
    plan.push_back(do_req(ask(OP_READ, VOL_RST, 48'd2, 32'd32768, 1'b1)));
    plan.push_back(do_req(ask(OP_READ, VOL_RST, 48'd33, 32'd2048, 1'b1)));
    plan.push_back(do_req(ask(OP_WRITE, VOL_RST, 48'd30, 32'd5120, 1'b1)));
    plan.push_back(do_req_exp(ask(OP_WRITE, VOL_RST, 48'd0, 32'd33280, 1'b1),
                              refusal(gor_pkg::ST_INVALID)));
    plan.push_back(do_req_exp(ask(OP_READ, VOL_RST, 48'd34, 32'd512, 1'b0),
                              refusal(gor_pkg::ST_INVALID)));
    plan.push_back(do_req_exp(ask(OP_READ, VOL_RST, 48'd34, 32'd0, 1'b1),
                              refusal(gor_pkg::ST_INVALID)));
    plan.push_back(do_req_exp(ask(OP_READ, VOL_RST, 48'd34, 32'd511, 1'b1),
                              refusal(gor_pkg::ST_INVALID)));
    plan.push_back(do_req_exp(ask(OP_READ, VOL_RST, 48'd0, 32'hFFFF_FE00, 1'b1),
                              refusal(gor_pkg::ST_INVALID)));
    plan.push_back(do_req_exp(ask(OP_READ, VOL_RST, 48'd67, 32'd1024, 1'b1),
                              refusal(gor_pkg::ST_INVALID)));
    plan.push_back(do_req_exp(ask(OP_READ, VOL_RST, '1, 32'd512, 1'b1),
                              refusal(gor_pkg::ST_INVALID)));
    plan.push_back(do_req_exp(ask(OP_READ, 32'd0, 48'd34, 32'd512, 1'b1),
                              refusal(gor_pkg::ST_MEDIA)));
    plan.push_back(do_req_exp(ask(OP_WRITE, '1, 48'd34, 32'd512, 1'b1),
                              refusal(gor_pkg::ST_MEDIA)));
    plan.push_back(do_cfg(gor_pkg::CFG_WRITE_LOCKED, 48'd1));
    plan.push_back(do_req_exp(ask(OP_WRITE, VOL_RST, 48'd34, 32'd512, 1'b1),
                              refusal(gor_pkg::ST_WRITE_PROT)));
    plan.push_back(do_req_exp(ask(OP_WRITE, 32'd0, 48'd34, 32'd0, 1'b0),
                              refusal(gor_pkg::ST_WRITE_PROT)));
    plan.push_back(do_req_exp(ask(OP_READ, VOL_RST, 48'd34, 32'd512, 1'b1),
                              routed(gor_pkg::RG_FORWARD, 64'd0, 64'd0, 64'd1, 1'b1)));
    plan.push_back(do_cfg(gor_pkg::CFG_WRITE_LOCKED, 48'd0));
    plan.push_back(do_cfg(gor_pkg::CFG_PASS_THROUGH, 48'd1));
    plan.push_back(do_req_exp(ask(OP_READ, VOL_RST, 48'd0, 32'd512, 1'b1),
                              routed(gor_pkg::RG_FORWARD, 64'd0, 64'd0, 64'd1, 1'b1)));
    plan.push_back(do_req_exp(ask(OP_WRITE, VOL_RST, 48'd0, 32'd1024, 1'b1),
                              refusal(gor_pkg::ST_INVALID)));
    // An empty extent in pass-through mode leaves no block to address.
    plan.push_back(do_cfg(gor_pkg::CFG_EXTENT_BLOCKS, 48'd0));
    plan.push_back(do_req_exp(ask(OP_READ, VOL_RST, 48'd0, 32'd512, 1'b1),
                              refusal(gor_pkg::ST_INVALID)));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < plan.size(); k++) begin
      if (plan[k].is_cfg) begin
        drain();
        write_reg(plan[k].idx, plan[k].wdata);
      end else begin
        issue(plan[k].req, plan[k].typed, plan[k].want);
      end
    end

    for (ph = 0; ph < N_PHASES; ph++) begin
      drain();
      gaps_on = (ph != N_PHASES - 1);
      case (ph)
        0: begin
          pass = 1'b0; lock = 1'b0; shift = '1; tbl = '1;
          base = '1; ext = '1; vol = '1;
        end
        1: begin
          pass = 1'b0; lock = 1'b0; shift = '0; tbl = '0;
          base = '0; ext = 48'd1; vol = '0;
        end
        2: begin
          // Pass-through at the top of the address space wraps the backing address.
          pass = 1'b1; lock = 1'b0; shift = gor_pkg::MAX_SHIFT;
          tbl = gor_pkg::MAX_TABLE_BLOCKS;
          base = '1; ext = '1; vol = $urandom;
        end
        default: begin
          pass  = ($urandom_range(3) == 0);
          lock  = (ph == 4) || ($urandom_range(5) == 0);
          shift = ($urandom_range(3) == 0)
                  ? 5'($urandom_range(31))
                  : 5'($urandom_range(gor_pkg::MIN_SHIFT, gor_pkg::MAX_SHIFT));
          tbl   = ($urandom_range(3) == 0) ? 6'($urandom_range(63))
                                           : 6'($urandom_range(gor_pkg::MAX_TABLE_BLOCKS));
          base  = rnd48();
          case ($urandom_range(7))
            0: ext = '0;
            1: ext = rnd48();
            default: ext = 48'($urandom_range(1, 150));
          endcase
          vol = $urandom;
        end
      endcase
      write_reg(CFG_NONE, rnd48());
      write_reg(gor_pkg::CFG_PASS_THROUGH, dress(48'(pass), 1));
      write_reg(gor_pkg::CFG_WRITE_LOCKED, dress(48'(lock), 1));
      write_reg(gor_pkg::CFG_BLOCK_SHIFT, dress(48'(shift), 5));
      write_reg(gor_pkg::CFG_TABLE_BLOCKS, dress(48'(tbl), 6));
      write_reg(gor_pkg::CFG_BACKING_BASE, base);
      write_reg(gor_pkg::CFG_EXTENT_BLOCKS, ext);
      write_reg(gor_pkg::CFG_VOLUME_ID, dress(48'(vol), 32));
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 3 && n == 7) drain();
        issue(draw_request(), 1'b0, '0);
      end
    end

    drain();
    if (mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
